>>> rtl/pdpt_pkg.sv
// ----------------------------------------------------------------------------
// pdpt_pkg: shared types and constants of the delay and pulse timer
// Timer modes, register indexes, the config port layout and the timer flags.
// ----------------------------------------------------------------------------
package pdpt_pkg;

    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DEF_COUNT_W   = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_MODE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_TICKS = 2'd1;

    typedef enum logic [1:0] {
        MODE_ON_DELAY  = 2'd0,
        MODE_OFF_DELAY = 2'd1,
        MODE_ON_OFF    = 2'd2,
        MODE_PULSE     = 2'd3
    } t_mode;

    typedef struct packed {
        logic prev_level;
        logic running;
        logic on_phase;
        logic off_phase;
    } t_flags;

    typedef struct packed {
        t_mode                 mode;
        logic [CFG_DATA_W-1:0] delay_ticks;
    } t_cfg;

endpackage

>>> rtl/pdpt_cfg.sv
// ----------------------------------------------------------------------------
// pdpt_cfg: configuration registers
// Holds the timer mode and the delay; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pdpt_cfg
    import pdpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_ON_DELAY;
            r_cfg.delay_ticks <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TIMER_MODE:  r_cfg.mode        <= t_mode'(i_cfg_wdata[1:0]);
                CFG_DELAY_TICKS: r_cfg.delay_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/pdpt_step.sv
// ----------------------------------------------------------------------------
// pdpt_step: one tick of the timer
// Next flags, next count and output level from the current state and a tick.
// ----------------------------------------------------------------------------
module pdpt_step
    import pdpt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_W
) (
    input  t_cfg                    i_cfg,
    input  logic                    i_level,
    input  logic                    i_rst_req,
    input  t_flags                  i_flags,
    input  logic signed [COUNT_WIDTH:0] i_count,
    output t_flags                  o_flags,
    output logic signed [COUNT_WIDTH:0] o_count,
    output logic                    o_level
);

    localparam logic signed [COUNT_WIDTH:0] MINUS_ONE = '1;

    function automatic logic signed [COUNT_WIDTH:0] dec(input logic signed [COUNT_WIDTH:0] c);
        logic signed [COUNT_WIDTH:0] r;
        r = c;
        if (c > MINUS_ONE) begin
            r = c + MINUS_ONE;
        end
        return r;
    endfunction

    logic signed [COUNT_WIDTH:0] w_load;
    assign w_load = $signed({1'b0, COUNT_WIDTH'(i_cfg.delay_ticks)});

    t_flags                      f;
    logic signed [COUNT_WIDTH:0] cnt;
    logic                        sel_on;
    logic                        sel_off;
    logic                        res;

    always_comb begin
        f       = i_flags;
        cnt     = i_count;
        res     = i_level;
        sel_on  = 1'b0;
        sel_off = 1'b0;

        if (i_cfg.mode == MODE_ON_OFF) begin
            if (i_level && !f.prev_level) begin
                f.on_phase  = 1'b1;
                f.off_phase = 1'b0;
                cnt         = w_load;
            end else if (!i_level && f.prev_level) begin
                f.on_phase  = 1'b0;
                f.off_phase = 1'b1;
                cnt         = w_load;
            end
        end

        case (i_cfg.mode)
            MODE_ON_DELAY:  sel_on  = 1'b1;
            MODE_OFF_DELAY: sel_off = 1'b1;
            MODE_ON_OFF: begin
                sel_on  = f.on_phase;
                sel_off = !f.on_phase && f.off_phase;
            end
            default: ;
        endcase

        if (sel_on) begin
            if (!i_level || i_rst_req) begin
                f.running = 1'b0;
            end else if (!f.prev_level) begin
                cnt       = w_load;
                f.running = 1'b1;
            end
            if (f.running) begin
                cnt = dec(cnt);
                if (cnt <= 0) begin
                    res       = 1'b1;
                    f.running = 1'b0;
                end else begin
                    res = 1'b0;
                end
            end else begin
                res = i_level;
            end
            f.prev_level = i_level;
        end else if (sel_off) begin
            if (i_level || i_rst_req) begin
                cnt       = w_load;
                f.running = 1'b0;
            end else if (f.prev_level) begin
                f.running = 1'b1;
            end
            if (f.running) begin
                cnt = dec(cnt);
                if (cnt <= 0) begin
                    res       = 1'b0;
                    f.running = 1'b0;
                end else begin
                    res = 1'b1;
                end
            end else begin
                res = i_level;
            end
            f.prev_level = i_level;
        end else if (i_cfg.mode == MODE_PULSE) begin
            if (i_level && !f.prev_level) begin
                cnt       = w_load;
                f.running = 1'b1;
            end
            if (f.running) begin
                cnt = dec(cnt);
                if (cnt <= 0) begin
                    res       = 1'b0;
                    f.running = 1'b0;
                end else begin
                    res = 1'b1;
                end
            end else begin
                res = 1'b0;
            end
            f.prev_level = i_level;
        end
    end

    assign o_flags = f;
    assign o_count = cnt;
    assign o_level = res;

endmodule

>>> rtl/plc_delay_pulse_timer.sv
// Throughput: one request per cycle while the result side is not stalled; the
// tick step is one pass of compare and decrement logic between the input
// register and the result register.
// Reset: synchronous, active low; clears mode, delay, flags, count and valids.
// ----------------------------------------------------------------------------
// plc_delay_pulse_timer: on-delay, off-delay, on/off-delay and pulse timer
// Tick requests carry level and reset; each yields one output level.
// ----------------------------------------------------------------------------
module plc_delay_pulse_timer
    import pdpt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_level_in,
    input  logic                  i_reset_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_level_out
);

    t_cfg w_cfg;

    logic r_in_valid;
    logic r_in_level;
    logic r_in_rst;
    logic r_out_valid;
    logic r_out_level;

    t_flags                      r_flags;
    t_flags                      n_flags;
    logic signed [COUNT_WIDTH:0] r_count;
    logic signed [COUNT_WIDTH:0] n_count;
    logic                        n_level;

    logic w_adv;

    pdpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    pdpt_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_cfg     (w_cfg),
        .i_level   (r_in_level),
        .i_rst_req (r_in_rst),
        .i_flags   (r_flags),
        .i_count   (r_count),
        .o_flags   (n_flags),
        .o_count   (n_count),
        .o_level   (n_level)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_level <= i_level_in;
            r_in_rst   <= i_reset_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_flags     <= n_flags;
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_level <= n_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level_out = r_out_level;

`ifndef SYNTHESIS
    a_count_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_count[COUNT_WIDTH] || (r_count == '1))
        else $error("tick count below floor");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipe");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_level) && $stable(r_in_rst)))
        else $error("held request lost");

    a_out_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

>>> tb/sv/pdpt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdpt_checker: tick predictor and result scoreboard for the timer
// Follows config writes and accepted tick requests and predicts each output
// level. It compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module pdpt_checker
    import pdpt_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_level_in,
    input  logic                  i_reset_req,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_level_out,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);

    t_mode                       mode_q;
    logic [CFG_DATA_W-1:0]       delay_q;
    logic                        last_level;
    logic                        counting;
    logic signed [COUNT_WIDTH:0] remaining;
    logic                        on_sel;
    logic                        off_sel;
    logic                        expected_levels[$];

    function automatic logic signed [COUNT_WIDTH:0] reload_count();
        logic [COUNT_WIDTH-1:0] span;
        span = COUNT_WIDTH'(delay_q);
        return $signed({1'b0, span});
    endfunction

    // hold the count at -1 once it has run out
    function automatic logic count_expired();
        if (remaining > -1)
            remaining = remaining - 1'b1;
        return remaining <= 0;
    endfunction

    function automatic logic on_delay_step(input logic lvl, input logic rst);
        logic res;
        if (!lvl || rst) begin
            counting = 1'b0;
        end else if (!last_level) begin
            remaining = reload_count();
            counting  = 1'b1;
        end
        if (counting) begin
            res = count_expired();
            if (res)
                counting = 1'b0;
        end else begin
            res = lvl;
        end
        last_level = lvl;
        return res;
    endfunction

    function automatic logic off_delay_step(input logic lvl, input logic rst);
        logic res;
        if (lvl || rst) begin
            remaining = reload_count();
            counting  = 1'b0;
        end else if (last_level) begin
            counting = 1'b1;
        end
        if (counting) begin
            res = !count_expired();
            if (!res)
                counting = 1'b0;
        end else begin
            res = lvl;
        end
        last_level = lvl;
        return res;
    endfunction

    function automatic logic next_level_out(input logic lvl, input logic rst);
        logic res;
        case (mode_q)
            MODE_ON_DELAY: res = on_delay_step(lvl, rst);
            MODE_OFF_DELAY: res = off_delay_step(lvl, rst);
            MODE_ON_OFF: begin
                if (lvl && !last_level) begin
                    on_sel    = 1'b1;
                    off_sel   = 1'b0;
                    remaining = reload_count();
                end else if (!lvl && last_level) begin
                    on_sel    = 1'b0;
                    off_sel   = 1'b1;
                    remaining = reload_count();
                end
                if (on_sel)
                    res = on_delay_step(lvl, rst);
                else if (off_sel)
                    res = off_delay_step(lvl, rst);
                else
                    res = lvl;
            end
            default: begin
                if (lvl && !last_level) begin
                    remaining = reload_count();
                    counting  = 1'b1;
                end
                if (counting) begin
                    res = !count_expired();
                    if (!res)
                        counting = 1'b0;
                end else begin
                    res = 1'b0;
                end
                last_level = lvl;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : track_timer
        logic want;
        if (!i_rst_n) begin
            mode_q         = MODE_ON_DELAY;
            delay_q        = '0;
            last_level     = 1'b0;
            counting       = 1'b0;
            remaining      = '0;
            on_sel         = 1'b0;
            off_sel        = 1'b0;
            expected_levels.delete();
            o_fail_count   = 0;
            o_pending      = 0;
            o_result_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_TIMER_MODE)
                    mode_q = t_mode'(i_cfg_wdata[1:0]);
                else if (i_cfg_addr == CFG_DELAY_TICKS)
                    delay_q = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready)
                expected_levels.push_back(next_level_out(i_level_in, i_reset_req));
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    $display("%0t: level_out expected none, got %0b", $time, i_level_out);
                    o_fail_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (i_level_out !== want) begin
                        $display("%0t: level_out expected %0b, got %0b",
                                 $time, want, i_level_out);
                        o_fail_count++;
                    end
                    o_result_count++;
                end
            end
            o_pending = expected_levels.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the delay and pulse timer
// Drives tick requests in bursts through directed and random timer settings,
// stalls the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import pdpt_pkg::*;

    localparam int                    CYCLE_LIMIT   = 400000;
    localparam int                    RANDOM_TICKS  = 1725;
    localparam int                    SQUEEZE_PHASE = 5;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct packed {
        logic level;
        logic rst;
    } t_tick;

    typedef enum logic [1:0] {
        DRAIN_FULL,
        DRAIN_RANDOM,
        DRAIN_PATTERN
    } t_drain;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic                  level_in    = 1'b0;
    logic                  reset_req   = 1'b0;
    logic                  out_ready   = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_level_out;

    int     fail_count;
    int     results_pending;
    int     results_checked;
    int     cycle_count   = 0;
    int     ticks_queued  = 0;
    int     ticks_sent    = 0;
    int     gap_left      = 0;
    int     burst_left    = 0;
    int     squeeze_req   = 0;
    int     squeeze_seen  = 0;
    int     hold_left     = 0;
    int     style_left    = 0;
    int     settings_used = 0;
    t_drain style         = DRAIN_FULL;
    logic [7:0] stall_mask = 8'hFF;
    t_tick  tick_queue[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    plc_delay_pulse_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_level_in  (level_in),
        .i_reset_req (reset_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_level_out (o_level_out)
    );

    pdpt_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_ready     (o_in_ready),
        .i_level_in     (level_in),
        .i_reset_req    (reset_req),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .i_level_out    (o_level_out),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending),
        .o_result_count (results_checked)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("plc_delay_pulse_timer test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive_ticks
        t_tick nxt;
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid)
                ticks_sent <= ticks_sent + 1;
            if (gap_left > 0 || tick_queue.size() == 0) begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end else begin
                nxt = tick_queue.pop_front();
                in_valid  <= 1'b1;
                level_in  <= nxt.level;
                reset_req <= nxt.rst;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left <= 0;
                        4: gap_left <= $urandom_range(9, 30);
                        default: gap_left <= $urandom_range(1, 8);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin : drain_results
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (squeeze_seen != squeeze_req) begin
            squeeze_seen <= squeeze_req;
            hold_left    <= 200;
            out_ready    <= 1'b0;
        end else if (style_left == 0) begin
            style      <= t_drain'($urandom_range(0, 2));
            style_left <= $urandom_range(20, 150);
            stall_mask <= 8'($urandom) | 8'h01;
            out_ready  <= 1'b1;
        end else begin
            style_left <= style_left - 1;
            stall_mask <= {stall_mask[0], stall_mask[7:1]};
            case (style)
                DRAIN_FULL: out_ready <= 1'b1;
                DRAIN_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= stall_mask[0];
            endcase
        end
    end

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (ticks_sent != ticks_queued || results_pending != 0);
    endtask

    task automatic configure(input t_mode mode, input logic [CFG_DATA_W-1:0] delay,
                             input bit poke_unused);
        wait_drained();
        repeat (3) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TIMER_MODE;
        cfg_wdata <= {14'($urandom), mode};
        @(posedge i_clk);
        cfg_addr  <= CFG_DELAY_TICKS;
        cfg_wdata <= delay;
        if (poke_unused) begin
            @(posedge i_clk);
            cfg_addr  <= CFG_UNUSED_LO;
            cfg_wdata <= 16'($urandom);
            @(posedge i_clk);
            cfg_addr  <= CFG_UNUSED_HI;
            cfg_wdata <= 16'hFFFF;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic push_tick(input logic lvl, input logic rst);
        t_tick t;
        t.level = lvl;
        t.rst   = rst;
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    // levels and resets are listed from bit 0 upward
    task automatic add_ticks(input int count, input logic [15:0] lvls,
                             input logic [15:0] rsts);
        for (int i = 0; i < count; i++)
            push_tick(lvls[i], rsts[i]);
    endtask

    task automatic fill_ticks(input int count, input int delay);
        int   reach;
        int   run;
        logic lvl;
        reach = (delay > 24) ? 24 : delay;
        lvl   = 1'($urandom_range(0, 1));
        while (count > 0) begin
            if ($urandom_range(0, 4) == 0) begin
                push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                count--;
            end else begin
                lvl = !lvl;
                run = $urandom_range(1, reach + 3);
                while (run > 0 && count > 0) begin
                    push_tick(lvl, $urandom_range(0, 11) == 0);
                    run--;
                    count--;
                end
            end
        end
    endtask

    initial begin : stimulus
        int                    phase;
        int                    random_ticks;
        int                    count;
        t_mode                 mode;
        logic [CFG_DATA_W-1:0] delay;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure(MODE_ON_DELAY, 16'd3, 1'b0);
        add_ticks(8, 16'h00EE, 16'h0004);
        configure(MODE_OFF_DELAY, 16'd2, 1'b0);
        add_ticks(6, 16'h0011, 16'h0020);
        configure(MODE_ON_OFF, 16'd2, 1'b1);
        add_ticks(6, 16'h000E, 16'h0008);
        configure(MODE_PULSE, 16'd4, 1'b0);
        add_ticks(5, 16'h000B, 16'h0001);

        phase        = 0;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            case (phase)
                0: delay = 16'd0;
                1: delay = 16'd1;
                2: delay = 16'hFFFF;
                3: delay = 16'd2;
                default: begin
                    case ($urandom_range(0, 9))
                        0: delay = 16'($urandom);
                        1, 2: delay = 16'($urandom_range(13, 200));
                        default: delay = 16'($urandom_range(0, 12));
                    endcase
                end
            endcase
            mode = (phase < 4) ? t_mode'(phase) : t_mode'($urandom_range(0, 3));
            configure(mode, delay, $urandom_range(0, 3) == 0);
            count = (phase == SQUEEZE_PHASE) ? 300 : $urandom_range(40, 120);
            fill_ticks(count, int'(delay));
            if (phase == SQUEEZE_PHASE)
                squeeze_req++;
            random_ticks += count;
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d tick results over %0d timer settings: all modes, delays 0 to 65535,",
                 results_checked, settings_used);
        $display("reset requests, unused register writes and a long output hold-off.");
        if (fail_count == 0 && results_pending == 0) begin
            $display("plc_delay_pulse_timer test passed");
        end else begin
            $display("plc_delay_pulse_timer test failed");
        end
        $finish;
    end

endmodule

>>> plc_delay_pulse_timer.f
rtl/pdpt_pkg.sv
rtl/pdpt_cfg.sv
rtl/pdpt_step.sv
rtl/plc_delay_pulse_timer.sv
tb/sv/pdpt_checker.sv
tb/sv/testbench.sv
